FILE: rtl/core/srb_pkg.sv
// Shared types and constants of the sample ring buffer.
package srb_pkg;

	localparam int DEPTH     = 4096;
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int CNT_W     = 13;
	localparam int LEN_W     = 7;
	localparam int SMP_W     = 16;
	localparam int MAX_BLOCK = 64;

	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
	localparam int OUTQ_LW    = $clog2(OUTQ_DEPTH + 2);

	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 32;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_NO_ROOM = 2'd1;
	localparam logic [1:0] STAT_SHORT   = 2'd2;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} state_t;

	typedef struct packed {
		logic [1:0]              status;
		logic                    has_sample;
		logic signed [SMP_W-1:0] out_sample;
		logic                    last;
		logic [CNT_W-1:0]        stored_count;
	} result_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [SMP_W-1:0]  wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

endpackage

FILE: rtl/core/srb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module srb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/core/srb_outq.sv
// Small result queue that decouples the controller from output back-pressure.
module srb_outq (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push_valid,
	input  srb_pkg::result_t         push_data,
	output logic [srb_pkg::OUTQ_LW-1:0] level,
	output logic                     m_valid,
	input  logic                     m_ready,
	output srb_pkg::result_t         m_data
);
	import srb_pkg::*;

	result_t              entry_q [OUTQ_DEPTH];
	logic [OUTQ_AW-1:0]   wr_idx_q;
	logic [OUTQ_AW-1:0]   rd_idx_q;
	logic [OUTQ_LW-1:0]   count_q;
	logic                 pop;

	assign m_valid = (count_q != '0);
	assign m_data  = entry_q[rd_idx_q];
	assign level   = count_q;
	assign pop     = m_valid & m_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_valid) begin
				wr_idx_q <= wr_idx_q + 1'b1;
			end
			if (pop) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			count_q <= count_q + OUTQ_LW'(push_valid) - OUTQ_LW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_valid) begin
			entry_q[wr_idx_q] <= push_data;
		end
	end

endmodule

FILE: rtl/core/srb_ctrl.sv
// Pointer, fill and block bookkeeping; issues store accesses and results.
module srb_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [srb_pkg::CNT_W-1:0]    cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         in_kind,
	input  logic [srb_pkg::SMP_W-1:0]    in_sample,
	input  logic [srb_pkg::LEN_W-1:0]    in_len,
	input  logic [srb_pkg::OUTQ_LW-1:0]  outq_level,
	output srb_pkg::ram_req_t            ram_req,
	input  logic [srb_pkg::SMP_W-1:0]    ram_rdata,
	output logic                         push_valid,
	output srb_pkg::result_t             push_data
);
	import srb_pkg::*;

	state_t            state_q, state_d;
	logic [ADDR_W-1:0] wr_ptr_q, wr_ptr_d;
	logic [ADDR_W-1:0] rd_ptr_q, rd_ptr_d;
	logic [CNT_W-1:0]  fill_q, fill_d;
	logic [LEN_W-1:0]  blk_rem_q, blk_rem_d;
	logic              blk_ref_q, blk_ref_d;
	logic [LEN_W-1:0]  rd_rem_q, rd_rem_d;
	logic [CNT_W-1:0]  cap_q;
	logic [CNT_W-1:0]  cap_new;

	logic              vld_s1, vld_d;
	result_t           res_s1, res_d;

	logic              room;
	logic [LEN_W-1:0]  len_sat;
	logic [LEN_W-1:0]  wlen;
	logic              refused;

	function automatic logic [ADDR_W-1:0] ptr_next(input logic [ADDR_W-1:0] p,
			input logic [CNT_W-1:0] cap);
		logic [CNT_W-1:0] n;
		n = CNT_W'(p) + 1'b1;
		return (n >= cap) ? '0 : ADDR_W'(n);
	endfunction

	assign room    = (outq_level + OUTQ_LW'(vld_s1)) < OUTQ_LW'(OUTQ_DEPTH);
	assign len_sat = (in_len > LEN_W'(MAX_BLOCK)) ? LEN_W'(MAX_BLOCK) : in_len;

	always_comb begin
		if (cfg_wdata == '0) begin
			cap_new = CNT_W'(1);
		end else if (cfg_wdata > CNT_W'(DEPTH)) begin
			cap_new = CNT_W'(DEPTH);
		end else begin
			cap_new = cfg_wdata;
		end
	end

	always_comb begin
		state_d   = state_q;
		wr_ptr_d  = wr_ptr_q;
		rd_ptr_d  = rd_ptr_q;
		fill_d    = fill_q;
		blk_rem_d = blk_rem_q;
		blk_ref_d = blk_ref_q;
		rd_rem_d  = rd_rem_q;
		in_ready  = 1'b0;
		vld_d     = 1'b0;
		res_d     = '0;
		res_d.last = 1'b1;
		ram_req   = '0;
		ram_req.waddr = wr_ptr_q;
		ram_req.wdata = in_sample;
		ram_req.raddr = rd_ptr_q;
		wlen      = blk_rem_q;
		refused   = blk_ref_q;
		if (blk_rem_q == '0) begin
			wlen    = (len_sat == '0) ? LEN_W'(1) : len_sat;
			refused = CNT_W'(wlen) > (cap_q - fill_q);
		end

		case (state_q)
			ST_IDLE: begin
				in_ready = room;
				if (in_valid && room) begin
					vld_d = 1'b1;
					if (!in_kind) begin
						if (!refused) begin
							ram_req.we = 1'b1;
							wr_ptr_d   = ptr_next(wr_ptr_q, cap_q);
							fill_d     = fill_q + 1'b1;
						end
						blk_rem_d = wlen - 1'b1;
						blk_ref_d = (blk_rem_d == '0) ? 1'b0 : refused;
						res_d.status       = refused ? STAT_NO_ROOM : STAT_OK;
						res_d.stored_count = fill_d;
					end else if (CNT_W'(len_sat) > fill_q) begin
						res_d.status       = STAT_SHORT;
						res_d.stored_count = fill_q;
					end else if (len_sat == '0) begin
						res_d.stored_count = fill_q;
					end else begin
						// result comes from the read sweep instead
						vld_d    = 1'b0;
						rd_rem_d = len_sat;
						state_d  = ST_READ;
					end
				end
			end
			ST_READ: begin
				if (room) begin
					vld_d              = 1'b1;
					ram_req.re         = 1'b1;
					rd_ptr_d           = ptr_next(rd_ptr_q, cap_q);
					fill_d             = fill_q - 1'b1;
					rd_rem_d           = rd_rem_q - 1'b1;
					res_d.has_sample   = 1'b1;
					res_d.last         = (rd_rem_q == LEN_W'(1));
					res_d.stored_count = fill_d;
					if (rd_rem_q == LEN_W'(1)) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			wr_ptr_q  <= '0;
			rd_ptr_q  <= '0;
			fill_q    <= '0;
			blk_rem_q <= '0;
			blk_ref_q <= 1'b0;
			rd_rem_q  <= '0;
			cap_q     <= CNT_W'(DEPTH);
			vld_s1    <= 1'b0;
		end else begin
			vld_s1 <= vld_d;
			if (cfg_we) begin
				// new capacity empties the buffer
				state_q   <= ST_IDLE;
				wr_ptr_q  <= '0;
				rd_ptr_q  <= '0;
				fill_q    <= '0;
				blk_rem_q <= '0;
				blk_ref_q <= 1'b0;
				rd_rem_q  <= '0;
				cap_q     <= cap_new;
			end else begin
				state_q   <= state_d;
				wr_ptr_q  <= wr_ptr_d;
				rd_ptr_q  <= rd_ptr_d;
				fill_q    <= fill_d;
				blk_rem_q <= blk_rem_d;
				blk_ref_q <= blk_ref_d;
				rd_rem_q  <= rd_rem_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		res_s1 <= res_d;
	end

	// read data lands in the cycle after the access, alongside its descriptor
	always_comb begin
		push_valid = vld_s1;
		push_data  = res_s1;
		push_data.out_sample = res_s1.has_sample ? ram_rdata : '0;
	end

endmodule

FILE: rtl/core/sample_ring_buffer_core.sv
// Top level of the sample ring buffer: controller, sample store and result queue.
//
// Usage:
//   s_axis carries one item per transfer: tuser[0] = kind (0 write, 1 read),
//   tdata = sample and block length. A write block is announced by its first
//   write item; every write item returns one result with the block verdict.
//   A read request for n samples (n clipped to 64) returns n results, each with
//   a sample, the last with tlast; a read of 0 or a read larger than the fill returns one.
//   cfg_we/cfg_wdata set the capacity (0 reads as 1, above 4096 as 4096) and
//   empty the buffer; write only when no results are outstanding.
// Timing:
//   A write item or a one-result read is taken in one s_axis transfer; its
//   result is registered in the controller's result stage, then in the result
//   queue, before it appears on m_axis. A read of n samples holds s_axis tready
//   low as it sweeps the store, one sample per cycle whenever the queue has room,
//   limited by the single read port of the sample RAM. A four-entry result queue
//   absorbs m_axis stalls; when it fills, the controller pauses, s_axis tready drops.
// Reset: capacity 4096, buffer empty; store contents stay undefined.
module sample_ring_buffer_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [srb_pkg::CNT_W-1:0]         cfg_wdata,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [srb_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // sample[15:0], block_len[22:16]
	input  logic [0:0]                        s_axis_tuser,  // kind[0]
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [srb_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // status[1:0], has_sample[2],
	                                                         // out_sample[18:3],
	                                                         // stored_count[31:19]
	output logic                              m_axis_tlast
);
	import srb_pkg::*;

	ram_req_t           ram_req;
	logic [SMP_W-1:0]   ram_rdata;
	logic               push_valid;
	result_t            push_data;
	result_t            m_res;
	logic [OUTQ_LW-1:0] outq_level;

	srb_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_kind    (s_axis_tuser[0]),
		.in_sample  (s_axis_tdata[SMP_W-1:0]),
		.in_len     (s_axis_tdata[SMP_W+LEN_W-1:SMP_W]),
		.outq_level (outq_level),
		.ram_req    (ram_req),
		.ram_rdata  (ram_rdata),
		.push_valid (push_valid),
		.push_data  (push_data)
	);

	srb_ram #(
		.WIDTH (SMP_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	srb_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.level      (outq_level),
		.m_valid    (m_axis_tvalid),
		.m_ready    (m_axis_tready),
		.m_data     (m_res)
	);

	assign m_axis_tdata = {m_res.stored_count, m_res.out_sample, m_res.has_sample, m_res.status};
	assign m_axis_tlast = m_res.last;

endmodule

FILE: verif/srb_tb_pkg.sv
// Item kind codes shared by the sample ring buffer testbench files.
package srb_tb_pkg;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_READ  = 1'b1;

endpackage

FILE: verif/srb_checker.sv
// Checker for the sample ring buffer: mirrors the ring, predicts every result and compares.
module srb_checker
	import srb_pkg::*;
	import srb_tb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CNT_W-1:0]      cfg_wdata,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // sample[15:0], block_len[22:16]
	input  logic [0:0]            s_axis_tuser,   // kind[0]
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [OUT_DATA_W-1:0] m_axis_tdata,   // status[1:0], has_sample[2],
	                                              // out_sample[18:3], stored_count[31:19]
	input  logic                  m_axis_tlast,
	output int                    errors,
	output int                    pending,
	output int                    stored
);

	result_t          due_results[$];
	logic [SMP_W-1:0] ring_mem [DEPTH];
	int               ring_cap = DEPTH;
	int               wr_slot = 0;
	int               rd_slot = 0;
	int               fill = 0;
	int               blk_left = 0;
	logic             blk_refused = 1'b0;
	int               n_err = 0;

	function automatic int next_slot(input int p);
		return (p + 1 >= ring_cap) ? 0 : p + 1;
	endfunction

	task automatic report_mismatch(input string msg);
		n_err++;
		$display("[%0t] ERROR: %s", $time, msg);
	endtask

	task automatic compare_field(input string name, input int got, input int want);
		if (got != want)
			report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
	endtask

	task automatic empty_ring();
		wr_slot     = 0;
		rd_slot     = 0;
		fill        = 0;
		blk_left    = 0;
		blk_refused = 1'b0;
	endtask

	task automatic queue_result(input logic [1:0] st, input logic has,
			input logic [SMP_W-1:0] smp, input logic lst);
		result_t r;
		r.status       = st;
		r.has_sample   = has;
		r.out_sample   = smp;
		r.last         = lst;
		r.stored_count = fill[CNT_W-1:0];
		due_results.push_back(r);
	endtask

	task automatic predict_item(input logic kind, input logic [SMP_W-1:0] smp,
			input logic [LEN_W-1:0] len_f);
		int               n;
		int               i;
		logic [SMP_W-1:0] v;
		n = (len_f > MAX_BLOCK) ? MAX_BLOCK : int'(len_f);
		if (kind == KIND_WRITE) begin
			// first item of a block reserves room for the whole block or refuses it
			if (blk_left == 0) begin
				if (n == 0)
					n = 1;
				blk_refused = (n > ring_cap - fill);
				blk_left    = n;
			end
			if (!blk_refused) begin
				ring_mem[wr_slot] = smp;
				wr_slot = next_slot(wr_slot);
				fill++;
			end
			blk_left--;
			queue_result(blk_refused ? STAT_NO_ROOM : STAT_OK, 1'b0, '0, 1'b1);
			if (blk_left == 0)
				blk_refused = 1'b0;
		end else if (n > fill) begin
			queue_result(STAT_SHORT, 1'b0, '0, 1'b1);
		end else if (n == 0) begin
			queue_result(STAT_OK, 1'b0, '0, 1'b1);
		end else begin
			for (i = 0; i < n; i++) begin
				v = ring_mem[rd_slot];
				rd_slot = next_slot(rd_slot);
				fill--;
				queue_result(STAT_OK, 1'b1, v, i == n - 1);
			end
		end
	endtask

	task automatic check_result(input result_t got);
		result_t want;
		if (due_results.size() == 0) begin
			report_mismatch($sformatf("result with nothing pending (stored_count %0d)",
				got.stored_count));
		end else begin
			want = due_results.pop_front();
			compare_field("status", int'(got.status), int'(want.status));
			compare_field("has_sample", int'(got.has_sample), int'(want.has_sample));
			compare_field("out_sample", int'(got.out_sample), int'(want.out_sample));
			compare_field("last", int'(got.last), int'(want.last));
			compare_field("stored_count", int'(got.stored_count),
				int'(want.stored_count));
		end
	endtask

	always @(posedge clk) begin : watch
		result_t got;
		if (!arst_n) begin
			ring_cap = DEPTH;
			empty_ring();
			due_results.delete();
		end else begin
			if (cfg_we) begin
				ring_cap = (cfg_wdata == 0) ? 1 :
					(int'(cfg_wdata) > DEPTH) ? DEPTH : int'(cfg_wdata);
				empty_ring();
			end
			// input transfer first: its results can only follow it
			if (s_axis_tvalid && s_axis_tready)
				predict_item(s_axis_tuser[0], s_axis_tdata[15:0], s_axis_tdata[22:16]);
			if (m_axis_tvalid && m_axis_tready) begin
				got.status       = m_axis_tdata[1:0];
				got.has_sample   = m_axis_tdata[2];
				got.out_sample   = m_axis_tdata[18:3];
				got.stored_count = m_axis_tdata[31:19];
				got.last         = m_axis_tlast;
				check_result(got);
			end
		end
		errors  <= n_err;
		pending <= due_results.size();
		stored  <= fill;
	end

endmodule

FILE: verif/tb_sample_ring_buffer_core.sv
// Testbench top for the sample ring buffer: stimulus, idling, capacity phases and verdict.
module tb_sample_ring_buffer_core;
	import srb_pkg::*;
	import srb_tb_pkg::*;

	localparam int CYCLE_LIMIT = 500000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CNT_W-1:0]      cfg_wdata = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [0:0]            s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tlast;

	int errors;
	int pending;
	int stored;
	int sent = 0;
	int cycles = 0;
	bit calm = 1'b0;
	int phase_caps [8] = '{2, 4096, 7, 1, 64, 8191, 13, 4097};

	sample_ring_buffer_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	srb_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.errors        (errors),
		.pending       (pending),
		.stored        (stored)
	);

	always #10 clk = ~clk;

	initial begin : watchdog
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	// result side: a random stall before each transfer, none while calm
	initial begin : sink
		int stall;
		forever begin
			stall = calm ? 0 : $urandom_range(0, 11);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
		end
	end

	task automatic send_item(input logic kind, input logic [SMP_W-1:0] smp,
			input logic [LEN_W-1:0] len);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= IN_DATA_W'($urandom);
			s_axis_tuser  <= 1'($urandom);
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= {1'b0, len, smp};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sent++;
	endtask

	// hold off until every predicted result has been seen
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_capacity(input int value);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= CNT_W'(value);
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	function automatic int pick_read_len();
		int lim;
		lim = (stored > MAX_BLOCK) ? MAX_BLOCK : stored;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(0, 127);
		if (lim == 0)
			return $urandom_range(0, 2);
		return $urandom_range(1, lim);
	endfunction

	task automatic write_block(input int len_field, input int n_items);
		int n;
		send_item(KIND_WRITE, SMP_W'($urandom), LEN_W'(len_field));
		for (n = 1; n < n_items; n++) begin
			if ($urandom_range(0, 7) == 0)
				send_item(KIND_READ, SMP_W'($urandom), LEN_W'(pick_read_len()));
			// block_len of later items is ignored, so it is random
			send_item(KIND_WRITE, SMP_W'($urandom), LEN_W'($urandom));
		end
	endtask

	task automatic random_phase(input int budget);
		int target;
		int r;
		int len;
		target = sent + budget;
		while (sent < target) begin
			r = $urandom_range(0, 99);
			if (r < 50) begin
				r = $urandom_range(0, 19);
				if (r == 0)
					len = 0;
				else if (r == 1)
					len = $urandom_range(65, 127);
				else if (r == 2)
					len = $urandom_range(9, 64);
				else
					len = $urandom_range(1, 8);
				write_block(len, (len == 0) ? 1 : (len > MAX_BLOCK) ? MAX_BLOCK : len);
			end else if (r < 95) begin
				send_item(KIND_READ, SMP_W'($urandom), LEN_W'(pick_read_len()));
			end else begin
				drain();
			end
		end
		// sometimes leave a block open for the next capacity write to cut off
		if ($urandom_range(0, 1) == 1)
			send_item(KIND_WRITE, SMP_W'($urandom), LEN_W'($urandom_range(2, 6)));
	endtask

	initial begin : stimulus
		int i;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(KIND_READ, 16'h0000, 7'd0);
		send_item(KIND_READ, 16'hFFFF, 7'd1);
		send_item(KIND_WRITE, 16'h7FFF, 7'd0);    // zero length stands for one
		send_item(KIND_WRITE, 16'h8000, 7'd3);
		send_item(KIND_WRITE, 16'h0000, 7'd127);
		send_item(KIND_WRITE, 16'hFFFF, 7'd0);
		send_item(KIND_READ, 16'h0000, 7'd127);   // clipped to 64, more than held
		send_item(KIND_READ, 16'h0000, 7'd4);
		send_item(KIND_WRITE, 16'h5555, 7'd2);
		send_item(KIND_READ, 16'h0000, 7'd1);     // served inside an open block
		send_item(KIND_WRITE, 16'hAAAA, 7'd64);
		send_item(KIND_READ, 16'hFFFF, 7'd1);

		set_capacity(3);
		send_item(KIND_WRITE, 16'h0001, 7'd2);
		send_item(KIND_WRITE, 16'h0002, 7'd0);
		send_item(KIND_WRITE, 16'h0003, 7'd2);    // one slot free: refused
		send_item(KIND_WRITE, 16'h0004, 7'd2);
		send_item(KIND_READ, 16'h0000, 7'd2);
		send_item(KIND_WRITE, 16'h0005, 7'd3);    // pointers wrap here
		send_item(KIND_WRITE, 16'h0006, 7'd0);
		send_item(KIND_WRITE, 16'h0007, 7'd0);
		send_item(KIND_READ, 16'h0000, 7'd3);
		send_item(KIND_WRITE, 16'h1234, 7'd127);  // refused and left open

		set_capacity(0);
		send_item(KIND_WRITE, 16'h1234, 7'd1);
		send_item(KIND_WRITE, 16'h4321, 7'd0);    // full: refused
		send_item(KIND_READ, 16'h0000, 7'd1);

		for (i = 0; i < 8; i++) begin
			set_capacity(phase_caps[i]);
			calm = (i % 3 == 1);
			random_phase(6);
		end
		calm = 1'b0;

		drain();
		repeat (16) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
